// File: hdl/sukt_pkg.sv
package sukt_pkg;

    // Field widths fixed by the interface.
    localparam int KEY_W    = 31;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 6;
    localparam int CNT_W    = 7;

    // Operation codes carried by func.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LIST   = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic ins_step;
        logic list_step;
        logic list_empty;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic count_zero;
        logic list_last;
        logic out_free;
    } sts_t;

endpackage

// File: hdl/sukt_ctrl.sv
module sukt_ctrl
    import sukt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic func,
    output logic in_stall,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // A new word is taken only while no operation is in progress.
    assign in_stall = (state_reg != S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (func == FUNC_LIST) ? S_LIST : S_INS;
                end
            end
            S_INS:
            begin
                if (sts.out_free)
                begin
                    cmd.ins_step = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (sts.out_free)
                begin
                    if (sts.count_zero)
                    begin
                        cmd.list_empty = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.list_step = 1'b1;
                        if (sts.list_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/sukt_dp.sv
module sukt_dp
    import sukt_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output sts_t                    sts,
    input  logic                    order_desc,
    input  logic [KEY_W-1:0]        key_id,
    input  logic [PAYLOAD_BITS-1:0] payload,
    input  logic                    out_stall,
    output logic                    out_valid,
    output logic [STATUS_W-1:0]     status,
    output logic [POS_W-1:0]        position,
    output logic [KEY_W-1:0]        entry_id,
    output logic [PAYLOAD_BITS-1:0] entry_payload,
    output logic [CNT_W-1:0]        count,
    output logic                    last
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Cell row.
    logic [KEY_W-1:0]        key_reg  [DEPTH];
    logic [KEY_W-1:0]        key_next [DEPTH];
    logic [PAYLOAD_BITS-1:0] pay_reg  [DEPTH];
    logic [PAYLOAD_BITS-1:0] pay_next [DEPTH];
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;

    // Operation captured on acceptance.
    logic [KEY_W-1:0]        op_key_reg;
    logic [PAYLOAD_BITS-1:0] op_pay_reg;
    logic [DEPTH-1:0]        match_reg;
    logic [DEPTH-1:0]        stop_reg;
    logic [IW-1:0]           lst_idx_reg;
    logic [IW-1:0]           lst_idx_next;

    // Output register.
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [STATUS_W-1:0]     status_reg;
    logic [STATUS_W-1:0]     status_next;
    logic [IW-1:0]           pos_reg;
    logic [IW-1:0]           pos_next;
    logic [KEY_W-1:0]        id_reg;
    logic [KEY_W-1:0]        id_next;
    logic [PAYLOAD_BITS-1:0] opay_reg;
    logic [PAYLOAD_BITS-1:0] opay_next;
    logic [CW-1:0]           cnt_reg;
    logic [CW-1:0]           cnt_next;
    logic                    last_reg;
    logic                    last_next;

    logic [DEPTH-1:0]        valid_vec;
    logic [DEPTH-1:0]        match_vec;
    logic [DEPTH-1:0]        stop_vec;
    logic [DEPTH-1:0]        stop_m1;
    logic [DEPTH-1:0]        stop_low;
    logic [DEPTH-1:0]        stop_above;
    logic [DEPTH-1:0]        ins_onehot;
    logic                    has_stop;
    logic                    dup;
    logic                    full;
    logic                    do_write;
    logic                    load;
    logic [IW-1:0]           dup_idx;
    logic [IW-1:0]           low_idx;
    logic [IW-1:0]           ins_idx;
    logic [PAYLOAD_BITS-1:0] dup_pay;

    // Each cell compares its own key with the incoming word.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cmp
            assign valid_vec[gi] = (count_reg > CW'(gi));
            assign match_vec[gi] = valid_vec[gi] && (key_reg[gi] == key_id);
            assign stop_vec[gi]  = valid_vec[gi] &&
                                   (order_desc ? (key_reg[gi] < key_id)
                                               : (key_reg[gi] > key_id));
        end
    endgenerate

    // The first stopping cell is the lowest set bit; cells above it move along.
    assign stop_m1    = stop_reg - DEPTH'(1);
    assign stop_low   = stop_reg & ~stop_m1;
    assign stop_above = ~(stop_reg ^ stop_m1);
    assign has_stop   = |stop_reg;
    assign dup        = |match_reg;
    assign full       = (count_reg == CW'(DEPTH));
    assign do_write   = cmd.ins_step && !dup && !full;
    assign load       = cmd.ins_step || cmd.list_step || cmd.list_empty;

    // One-hot to index encoders and the matched entry's payload.
    always_comb
    begin
        dup_idx = '0;
        low_idx = '0;
        dup_pay = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (match_reg[i])
            begin
                dup_pay = dup_pay | pay_reg[i];
            end
            for (int b = 0; b < IW; b++)
            begin
                if (((i >> b) & 1) == 1)
                begin
                    dup_idx[b] = dup_idx[b] | match_reg[i];
                    low_idx[b] = low_idx[b] | stop_low[i];
                end
            end
        end
    end

    assign ins_idx = has_stop ? low_idx : IW'(count_reg);

    // Cell update: insert with shift, or rotate by one place while listing.
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign ins_onehot[gi] = has_stop ? stop_low[gi] : (count_reg == CW'(gi));

            always_comb
            begin
                key_next[gi] = key_reg[gi];
                pay_next[gi] = pay_reg[gi];
                if (do_write)
                begin
                    if (ins_onehot[gi])
                    begin
                        key_next[gi] = op_key_reg;
                        pay_next[gi] = op_pay_reg;
                    end
                    else if (has_stop && stop_above[gi])
                    begin
                        if (gi > 0)
                        begin
                            key_next[gi] = key_reg[(gi > 0) ? gi - 1 : 0];
                            pay_next[gi] = pay_reg[(gi > 0) ? gi - 1 : 0];
                        end
                    end
                end
                else if (cmd.list_step && valid_vec[gi])
                begin
                    if ((gi == DEPTH - 1) || (count_reg == CW'(gi + 1)))
                    begin
                        key_next[gi] = key_reg[0];
                        pay_next[gi] = pay_reg[0];
                    end
                    else
                    begin
                        key_next[gi] = key_reg[(gi < DEPTH - 1) ? gi + 1 : gi];
                        pay_next[gi] = pay_reg[(gi < DEPTH - 1) ? gi + 1 : gi];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                key_reg[gi] <= key_next[gi];
                pay_reg[gi] <= pay_next[gi];
            end
        end
    endgenerate

    // Entry count and list index.
    assign count_next   = do_write ? (count_reg + CW'(1)) : count_reg;
    assign lst_idx_next = cmd.capture   ? '0 :
                          cmd.list_step ? (lst_idx_reg + IW'(1)) : lst_idx_reg;

    // Result word selection.
    always_comb
    begin
        status_next = status_reg;
        pos_next    = pos_reg;
        id_next     = id_reg;
        opay_next   = opay_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        if (cmd.ins_step)
        begin
            last_next = 1'b1;
            id_next   = op_key_reg;
            cnt_next  = count_reg;
            if (dup)
            begin
                status_next = ST_DUPLICATE;
                pos_next    = dup_idx;
                opay_next   = dup_pay;
            end
            else if (full)
            begin
                status_next = ST_FULL;
                pos_next    = '0;
                opay_next   = op_pay_reg;
            end
            else
            begin
                status_next = ST_INSERTED;
                pos_next    = ins_idx;
                opay_next   = op_pay_reg;
                cnt_next    = count_reg + CW'(1);
            end
        end
        else if (cmd.list_step)
        begin
            status_next = ST_LISTED;
            pos_next    = lst_idx_reg;
            id_next     = key_reg[0];
            opay_next   = pay_reg[0];
            cnt_next    = count_reg;
            last_next   = sts.list_last;
        end
        else if (cmd.list_empty)
        begin
            status_next = ST_EMPTY;
            pos_next    = '0;
            id_next     = '0;
            opay_next   = '0;
            cnt_next    = '0;
            last_next   = 1'b1;
        end
    end

    assign out_valid_next = load || (out_valid_reg && out_stall);

    // Status back to the controller.
    assign sts.count_zero = (count_reg == '0);
    assign sts.list_last  = ((CW'(lst_idx_reg) + CW'(1)) == count_reg);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            lst_idx_reg   <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            lst_idx_reg   <= lst_idx_next;
        end
    end

    // Captured operation and result word.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_key_reg <= key_id;
            op_pay_reg <= payload;
            match_reg  <= match_vec;
            stop_reg   <= stop_vec;
        end
        status_reg <= status_next;
        pos_reg    <= pos_next;
        id_reg     <= id_next;
        opay_reg   <= opay_next;
        cnt_reg    <= cnt_next;
        last_reg   <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign position      = POS_W'(pos_reg);
    assign entry_id      = id_reg;
    assign entry_payload = opay_reg;
    assign count         = CNT_W'(cnt_reg);
    assign last          = last_reg;

endmodule

// File: hdl/sorted_unique_key_table.sv
// Insert: on acceptance the compare results of the cell row are captured; the shift
// pass then writes the row and the result word into the output register once it is
// free, and no new word is taken before that. List of n entries: n result words after
// acceptance (one empty word if the table is empty); the row rotates one place a cycle
// while the output is free. Reset clears the entry count, the order bit and the output
// valid; cell contents are not cleared and are never read beyond the count.
module sorted_unique_key_table
    import sukt_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    func,
    input  logic [KEY_W-1:0]        key_id,
    input  logic [PAYLOAD_BITS-1:0] payload,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [STATUS_W-1:0]     status,
    output logic [POS_W-1:0]        position,
    output logic [KEY_W-1:0]        entry_id,
    output logic [PAYLOAD_BITS-1:0] entry_payload,
    output logic [CNT_W-1:0]        count,
    output logic                    last
);

    cmd_t cmd;
    sts_t sts;
    logic order_desc_reg;
    logic order_desc_next;

    // Order configuration register.
    assign cfg_ready       = 1'b1;
    assign order_desc_next = (cfg_valid && cfg_ready) ? cfg_data : order_desc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_desc_reg <= 1'b0;
        end
        else
        begin
            order_desc_reg <= order_desc_next;
        end
    end

    // Controller.
    sukt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Cell row and output register.
    sukt_dp #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .order_desc    (order_desc_reg),
        .key_id        (key_id),
        .payload       (payload),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .status        (status),
        .position      (position),
        .entry_id      (entry_id),
        .entry_payload (entry_payload),
        .count         (count),
        .last          (last)
    );

    // A word that is taken makes the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after an accepted word");

    // A full result only arises when the table holds DEPTH entries.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL)) |-> (count == CNT_W'(DEPTH)))
        else $error("full result with table not full");

    // An empty list result is a single final word with zero count.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_EMPTY)) |-> (last && (count == '0)))
        else $error("empty list result malformed");

endmodule
